// ===== rtl/core/cfs_pkg.sv =====
package cfs_pkg;

    localparam int TableEntries = 64;
    localparam int MaxReplBytes = 15;

    localparam int CpW       = 21;
    localparam int LenW      = 4;
    localparam int ByteW     = 8;
    localparam int IdxW      = $clog2(TableEntries);
    localparam int UsedW     = $clog2(TableEntries + 1);
    localparam int ByteAddrW = $clog2(TableEntries * MaxReplBytes);

    localparam logic [CpW-1:0] CharUpperA = CpW'('h41);
    localparam logic [CpW-1:0] CharUpperZ = CpW'('h5A);
    localparam logic [CpW-1:0] CaseOffset = CpW'('h20);

    typedef enum logic [1:0] {
        OP_FOLD        = 2'd0,
        OP_WRITE_KEY   = 2'd1,
        OP_WRITE_BYTE  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic wr_key;
        logic wr_byte;
        logic scan_next;
        logic take_hit;
        logic take_miss;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic len_zero;
        logic last;
    } status_t;

endpackage

// ===== rtl/core/collation_fold_stream.sv =====
// Folds code points into a sort-key byte stream, zero to 15 output bytes per fold.
// Table writes are taken while idle. A fold is accepted, then scans the key
// table one entry per cycle through its single read port: a hit on entry i
// ends the scan there; a miss scans max(entries_in_use, 1) entries, capped at 64.
// Bytes then leave at one per cycle while m_ready is high. The next request is
// taken once the last byte of the current fold has been accepted.
module collation_fold_stream
    import cfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [UsedW-1:0]  cfg_entries_in_use,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [IdxW-1:0]   s_entry_index,
    input  logic [CpW-1:0]    s_code_point,
    input  logic [LenW-1:0]   s_repl_length,
    input  logic [LenW-1:0]   s_byte_pos,
    input  logic [ByteW-1:0]  s_byte_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ByteW-1:0]  m_out_byte,
    output logic              m_last_byte,
    output logic              m_from_table
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfs_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_entries_in_use (cfg_entries_in_use),
        .s_entry_index      (s_entry_index),
        .s_code_point       (s_code_point),
        .s_repl_length      (s_repl_length),
        .s_byte_pos         (s_byte_pos),
        .s_byte_value       (s_byte_value),
        .cmd                (cmd),
        .status             (status),
        .m_out_byte         (m_out_byte),
        .m_last_byte        (m_last_byte),
        .m_from_table       (m_from_table)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while output pending");

    a_fold_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_FOLD)) |=> !m_valid)
        else $error("output without scan cycle");

    a_more_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=> m_valid)
        else $error("fold output ended early");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_byte) |=> (s_ready && !m_valid))
        else $error("not idle after last byte");

endmodule

// ===== rtl/core/cfs_ctrl.sv =====
module cfs_ctrl
    import cfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    output logic       m_valid,
    input  logic       m_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_opcode)
                        OP_FOLD: begin
                            cmd.capture = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        OP_WRITE_KEY:  cmd.wr_key  = 1'b1;
                        OP_WRITE_BYTE: cmd.wr_byte = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (status.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = status.len_zero ? ST_IDLE : ST_EMIT;
                end else if (status.scan_done) begin
                    cmd.take_miss = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/cfs_datapath.sv =====
module cfs_datapath
    import cfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [UsedW-1:0]     cfg_entries_in_use,
    input  logic [IdxW-1:0]      s_entry_index,
    input  logic [CpW-1:0]       s_code_point,
    input  logic [LenW-1:0]      s_repl_length,
    input  logic [LenW-1:0]      s_byte_pos,
    input  logic [ByteW-1:0]     s_byte_value,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [ByteW-1:0]     m_out_byte,
    output logic                 m_last_byte,
    output logic                 m_from_table
);

    logic [CpW+LenW-1:0]  key_mem [TableEntries];
    logic [ByteW-1:0]     byte_mem [TableEntries*MaxReplBytes];

    logic [UsedW-1:0]     used_reg;
    logic [CpW-1:0]       cp_reg;
    logic [CpW-1:0]       cp_next;
    logic [IdxW-1:0]      idx_reg;
    logic [IdxW-1:0]      idx_next;
    logic [ByteAddrW-1:0] base_reg;
    logic [ByteAddrW-1:0] base_next;
    logic [LenW-1:0]      pos_reg;
    logic [LenW-1:0]      pos_next;
    logic [LenW-1:0]      len_reg;
    logic [LenW-1:0]      len_next;
    logic                 from_table_reg;
    logic                 from_table_next;
    logic [CpW+LenW-1:0]  key_rd_reg;
    logic [ByteW-1:0]     byte_rd_reg;

    logic [UsedW-1:0]     used_eff;
    logic [CpW-1:0]       rd_key;
    logic [LenW-1:0]      rd_len;
    logic [LenW-1:0]      wr_len;
    logic [ByteAddrW-1:0] wr_addr;
    logic [ByteAddrW-1:0] rd_addr;
    logic [CpW-1:0]       fold_cp;
    logic [ByteW-1:0]     enc_byte [4];
    logic [LenW-1:0]      enc_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            used_reg <= cfg_entries_in_use;
        end
    end

    assign used_eff = (used_reg > UsedW'(TableEntries)) ? UsedW'(TableEntries) : used_reg;

    // key store and replacement byte store
    assign wr_len  = (s_repl_length > LenW'(MaxReplBytes)) ? LenW'(MaxReplBytes)
                                                            : s_repl_length;
    assign wr_addr = ByteAddrW'(s_entry_index) * ByteAddrW'(MaxReplBytes)
                   + ByteAddrW'(s_byte_pos);

    always_ff @(posedge aclk) begin
        if (cmd.wr_key) begin
            key_mem[s_entry_index] <= {s_code_point, wr_len};
        end
        key_rd_reg <= key_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte && (s_byte_pos < LenW'(MaxReplBytes))) begin
            byte_mem[wr_addr] <= s_byte_value;
        end
        byte_rd_reg <= byte_mem[rd_addr];
    end

    assign rd_key = key_rd_reg[CpW+LenW-1:LenW];
    assign rd_len = key_rd_reg[LenW-1:0];

    assign status.hit       = ({1'b0, idx_reg} < used_eff) && (rd_key == cp_reg);
    assign status.scan_done = ({1'b0, idx_reg} + UsedW'(1)) >= used_eff;
    assign status.len_zero  = (rd_len == '0);
    assign status.last      = ({1'b0, pos_reg} + (LenW+1)'(1)) == {1'b0, len_reg};

    // ASCII uppercase folds to lowercase only on a miss
    assign fold_cp = (cp_reg inside {[CharUpperA:CharUpperZ]}) ? cp_reg + CaseOffset
                                                              : cp_reg;

    // UTF-8 encoding of the folded code point
    always_comb begin
        enc_byte[0] = '0;
        enc_byte[1] = '0;
        enc_byte[2] = '0;
        enc_byte[3] = '0;
        if (fold_cp < CpW'('h80)) begin
            enc_byte[0] = fold_cp[7:0];
            enc_count   = LenW'(1);
        end else if (fold_cp < CpW'('h800)) begin
            enc_byte[0] = {3'b110, fold_cp[10:6]};
            enc_byte[1] = {2'b10, fold_cp[5:0]};
            enc_count   = LenW'(2);
        end else if (fold_cp < CpW'('h10000)) begin
            enc_byte[0] = {4'b1110, fold_cp[15:12]};
            enc_byte[1] = {2'b10, fold_cp[11:6]};
            enc_byte[2] = {2'b10, fold_cp[5:0]};
            enc_count   = LenW'(3);
        end else begin
            enc_byte[0] = {5'b11110, fold_cp[20:18]};
            enc_byte[1] = {2'b10, fold_cp[17:12]};
            enc_byte[2] = {2'b10, fold_cp[11:6]};
            enc_byte[3] = {2'b10, fold_cp[5:0]};
            enc_count   = LenW'(4);
        end
    end

    always_comb begin
        cp_next         = cp_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        from_table_next = from_table_reg;
        if (cmd.capture) begin
            idx_next = '0;
            cp_next  = s_code_point;
        end
        if (cmd.scan_next) begin
            idx_next = idx_reg + IdxW'(1);
        end
        if (cmd.take_hit) begin
            base_next       = ByteAddrW'(idx_reg) * ByteAddrW'(MaxReplBytes);
            len_next        = rd_len;
            pos_next        = '0;
            from_table_next = 1'b1;
        end
        if (cmd.take_miss) begin
            len_next        = enc_count;
            pos_next        = '0;
            from_table_next = 1'b0;
        end
        if (cmd.emit_next) begin
            pos_next = pos_reg + LenW'(1);
        end
    end

    assign rd_addr = base_next + ByteAddrW'(pos_next);

    always_ff @(posedge aclk) begin
        cp_reg         <= cp_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        pos_reg        <= pos_next;
        len_reg        <= len_next;
        from_table_reg <= from_table_next;
    end

    assign m_out_byte   = from_table_reg ? byte_rd_reg : enc_byte[pos_reg[1:0]];
    assign m_last_byte  = status.last;
    assign m_from_table = from_table_reg;

endmodule

// ===== verif/tb_collation_fold_stream.sv =====
module tb_collation_fold_stream
    import cfs_pkg::*;
();

    localparam logic [1:0] OpUnused = 2'd3;
    localparam int SettleCycles = 80;
    localparam int HoldCycles = 400;
    localparam int PhaseItems = 7;
    localparam logic [UsedW-1:0] PhaseUsed [6] = '{7'd17, 7'd64, 7'd127, 7'd1, 7'd0, 7'd40};

    typedef struct packed {
        logic [1:0]       op;
        logic [IdxW-1:0]  idx;
        logic [CpW-1:0]   cp;
        logic [LenW-1:0]  len;
        logic [LenW-1:0]  pos;
        logic [ByteW-1:0] val;
    } fold_req_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
        logic             from_table;
    } key_byte_t;

    typedef struct packed {
        logic             set_cfg;
        logic [UsedW-1:0] cfg_val;
        fold_req_t        req;
        logic             typed;
        logic [2:0]       n_typed;
        logic [31:0]      bytes_typed;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [UsedW-1:0]  cfg_entries_in_use = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode = '0;
    logic [IdxW-1:0]   s_entry_index = '0;
    logic [CpW-1:0]    s_code_point = '0;
    logic [LenW-1:0]   s_repl_length = '0;
    logic [LenW-1:0]   s_byte_pos = '0;
    logic [ByteW-1:0]  s_byte_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ByteW-1:0]  m_out_byte;
    logic              m_last_byte;
    logic              m_from_table;

    // predictor state
    bit [CpW-1:0]   fold_keys [TableEntries];
    bit [LenW-1:0]  fold_lens [TableEntries];
    bit [ByteW-1:0] fold_repl [TableEntries][MaxReplBytes];
    bit             key_written [TableEntries];
    bit             repl_written [TableEntries][MaxReplBytes];
    bit [UsedW-1:0] active_entries;

    key_byte_t   predicted_bytes [$];
    key_byte_t   awaited_bytes [$];
    int unsigned fail_count = 0;
    bit          steady = 1'b0;
    dir_row_t    dir_rows [26];

    collation_fold_stream u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_entries_in_use (cfg_entries_in_use),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_entry_index      (s_entry_index),
        .s_code_point       (s_code_point),
        .s_repl_length      (s_repl_length),
        .s_byte_pos         (s_byte_pos),
        .s_byte_value       (s_byte_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_last_byte        (m_last_byte),
        .m_from_table       (m_from_table)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void add_byte(logic [ByteW-1:0] data, logic last, logic from_table);
        key_byte_t b;
        b.data = data;
        b.last = last;
        b.from_table = from_table;
        predicted_bytes.push_back(b);
    endfunction

    function automatic void predict_fold_bytes(input fold_req_t r);
        logic [CpW-1:0] cp;
        int span;
        int n;
        predicted_bytes.delete();
        case (r.op)
            OP_WRITE_KEY: begin
                fold_keys[r.idx] = r.cp;
                fold_lens[r.idx] = (r.len > MaxReplBytes) ? LenW'(MaxReplBytes) : r.len;
                key_written[r.idx] = 1'b1;
            end
            OP_WRITE_BYTE: begin
                if (r.pos < MaxReplBytes) begin
                    fold_repl[r.idx][r.pos] = r.val;
                    repl_written[r.idx][r.pos] = 1'b1;
                end
            end
            OP_FOLD: begin
                span = (active_entries > TableEntries) ? TableEntries : active_entries;
                for (int i = 0; i < span; i++) begin
                    if (fold_keys[i] == r.cp) begin
                        n = fold_lens[i];
                        for (int j = 0; j < n; j++)
                            add_byte(fold_repl[i][j], j == n - 1, 1'b1);
                        return;
                    end
                end
                cp = r.cp;
                if (cp >= CharUpperA && cp <= CharUpperZ)
                    cp = cp + CaseOffset;
                if (cp < 'h80) begin
                    add_byte(cp[7:0], 1'b1, 1'b0);
                end else if (cp < 'h800) begin
                    add_byte({3'b110, cp[10:6]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
                end else if (cp < 'h10000) begin
                    add_byte({4'b1110, cp[15:12]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
                end else begin
                    add_byte({5'b11110, cp[20:18]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[17:12]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
                    add_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic fold_req_t rand_req();
        return fold_req_t'({$urandom(), $urandom()});
    endfunction

    function automatic logic [CpW-1:0] pick_code_point();
        case ($urandom_range(4))
            0: return CpW'($urandom_range('h7F));
            1: return CpW'($urandom_range('h7FF, 'h80));
            2: return CpW'($urandom_range('hFFFF, 'h800));
            3: return CpW'($urandom_range('h1FFFFF, 'h10000));
            default: return CpW'($urandom_range('h5A, 'h41));
        endcase
    endfunction

    function automatic int rand_len();
        case ($urandom_range(9))
            0: return MaxReplBytes;
            1: return $urandom_range(MaxReplBytes);
            default: return $urandom_range(4);
        endcase
    endfunction

    function automatic dir_row_t fold_row(logic [CpW-1:0] cp, int n, logic [31:0] b);
        dir_row_t d;
        d = '0;
        d.req.op = OP_FOLD;
        d.req.cp = cp;
        d.typed = (n >= 0);
        d.n_typed = n[2:0];
        d.bytes_typed = b;
        return d;
    endfunction

    function automatic dir_row_t silent_row(logic [1:0] op, logic [IdxW-1:0] idx,
            logic [CpW-1:0] cp, logic [LenW-1:0] len, logic [LenW-1:0] pos,
            logic [ByteW-1:0] val);
        dir_row_t d;
        d = '0;
        d.req = '{op: op, idx: idx, cp: cp, len: len, pos: pos, val: val};
        d.typed = 1'b1;
        return d;
    endfunction

    function automatic dir_row_t cfg_row(logic [UsedW-1:0] v);
        dir_row_t d;
        d = '0;
        d.set_cfg = 1'b1;
        d.cfg_val = v;
        return d;
    endfunction

    // n_typed < 0: expectation comes from the predictor
    task automatic issue(input fold_req_t r, input int n_typed, input logic [31:0] typed);
        key_byte_t b;
        while (!steady && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= r.op;
        s_entry_index <= r.idx;
        s_code_point  <= r.cp;
        s_repl_length <= r.len;
        s_byte_pos    <= r.pos;
        s_byte_value  <= r.val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_fold_bytes(r);
        if (n_typed < 0) begin
            foreach (predicted_bytes[k]) awaited_bytes.push_back(predicted_bytes[k]);
        end else begin
            for (int k = 0; k < n_typed; k++) begin
                b.data = typed[8 * (n_typed - 1 - k) +: 8];
                b.last = (k == n_typed - 1);
                b.from_table = 1'b0;
                awaited_bytes.push_back(b);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_bytes.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [UsedW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_entries_in_use <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        active_entries = v;
    endtask

    // key request, then nbytes of its replacement bytes in either order
    task automatic load_entry(input int idx, input logic [CpW-1:0] key, input int len,
            input int nbytes);
        fold_req_t r;
        bit down;
        r = rand_req();
        r.op = OP_WRITE_KEY;
        r.idx = IdxW'(idx);
        r.cp = key;
        r.len = LenW'(len);
        issue(r, -1, '0);
        down = $urandom_range(1);
        for (int k = 0; k < nbytes; k++) begin
            r = rand_req();
            r.op = OP_WRITE_BYTE;
            r.idx = IdxW'(idx);
            r.pos = LenW'(down ? len - 1 - k : k);
            issue(r, -1, '0);
            if ($urandom_range(9) == 0) begin
                r.pos = 4'd15;
                issue(r, -1, '0);
            end
        end
    endtask

    // result side: ready pattern and checking
    initial begin
        key_byte_t want;
        int seen;
        bit held;
        seen = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (awaited_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h", m_out_byte);
                    fail_count++;
                end else begin
                    want = awaited_bytes.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_last_byte !== want.last) begin
                        $error("last_byte: expected %b, got %b", want.last, m_last_byte);
                        fail_count++;
                    end
                    if (m_from_table !== want.from_table) begin
                        $error("from_table: expected %b, got %b", want.from_table,
                               m_from_table);
                        fail_count++;
                    end
                end
                seen++;
            end
            if (!held && seen >= 20) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            m_ready <= (seen >= 30 && seen < 70) || ($urandom_range(99) >= 38);
        end
    end

    initial begin : stimulus
        fold_req_t r;
        int pick;
        int span;
        int idx;
        int len;
        bit ready;

        dir_rows = '{
            fold_row(21'h0, 1, 32'h00),
            fold_row(21'h41, 1, 32'h61),
            fold_row(21'h5A, 1, 32'h7A),
            fold_row(21'h40, 1, 32'h40),
            fold_row(21'h5B, 1, 32'h5B),
            fold_row(21'h80, 2, 32'hC280),
            fold_row(21'h7FF, 2, 32'hDFBF),
            fold_row(21'h800, 3, 32'hE0A080),
            fold_row(21'hD800, 3, 32'hEDA080),
            fold_row(21'hFFFF, 3, 32'hEFBFBF),
            fold_row(21'h10000, 4, 32'hF0908080),
            fold_row(21'h1FFFFF, 4, 32'hF7BFBFBF),
            silent_row(OpUnused, 6'd63, 21'h1FFFFF, 4'd15, 4'd15, 8'hFF),
            silent_row(OP_WRITE_KEY, 6'd0, 21'h41, 4'd0, 4'd0, 8'h00),
            silent_row(OP_WRITE_KEY, 6'd1, 21'hE9, 4'd2, 4'd0, 8'h00),
            silent_row(OP_WRITE_BYTE, 6'd1, 21'h0, 4'd0, 4'd0, 8'h00),
            silent_row(OP_WRITE_BYTE, 6'd1, 21'h0, 4'd0, 4'd1, 8'hFF),
            silent_row(OP_WRITE_BYTE, 6'd1, 21'h0, 4'd0, 4'd15, 8'hAA),
            silent_row(OP_WRITE_KEY, 6'd2, 21'h41, 4'd3, 4'd0, 8'h00),
            silent_row(OP_WRITE_BYTE, 6'd63, 21'h0, 4'd0, 4'd14, 8'h5A),
            cfg_row(7'd3),
            fold_row(21'h41, 0, 32'h0),      // empty replacement wins over entry 2
            fold_row(21'hE9, -1, 32'h0),
            fold_row(21'h42, 1, 32'h62),
            cfg_row(7'd0),
            fold_row(21'h41, 1, 32'h61)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_cfg) begin
                wait_drained();
                write_cfg(dir_rows[i].cfg_val);
            end else begin
                issue(dir_rows[i].req, dir_rows[i].typed ? int'(dir_rows[i].n_typed) : -1,
                      dir_rows[i].bytes_typed);
            end
        end

        for (int p = 0; p < 6; p++) begin
            span = (PhaseUsed[p] > TableEntries) ? TableEntries : PhaseUsed[p];
            // every entry in the lookup range gets a key and all of its bytes
            for (int i = 0; i < span; i++) begin
                ready = key_written[i];
                for (int j = 0; j < fold_lens[i]; j++) ready = ready && repl_written[i][j];
                if (!ready) begin
                    len = $urandom_range(1);
                    load_entry(i, pick_code_point(), len, len);
                end
            end
            wait_drained();
            write_cfg(PhaseUsed[p]);
            steady = (p == 2);

            for (int n = 0; n < PhaseItems; n++) begin
                if (p == 0 && n == 3)
                    wait_drained();
                pick = $urandom_range(99);
                if (pick < 55) begin
                    r = rand_req();
                    r.op = OP_FOLD;
                    if (span > 0 && $urandom_range(99) < 40)
                        r.cp = fold_keys[$urandom_range(span - 1)];
                    else
                        r.cp = pick_code_point();
                    issue(r, -1, '0);
                end else if (pick < 80) begin
                    idx = $urandom_range(TableEntries - 1);
                    len = rand_len();
                    if (key_written[idx ^ 1] && $urandom_range(3) == 0)
                        load_entry(idx, fold_keys[idx ^ 1], len, len);
                    else
                        load_entry(idx, pick_code_point(), len, len);
                end else if (pick < 93) begin
                    r = rand_req();
                    r.op = OP_WRITE_BYTE;
                    issue(r, -1, '0);
                end else if (pick < 97 && span < TableEntries) begin
                    // possibly incomplete entry outside the lookup range
                    idx = $urandom_range(TableEntries - 1, span);
                    len = rand_len();
                    load_entry(idx, pick_code_point(), len, $urandom_range(len));
                end else begin
                    r = rand_req();
                    r.op = OpUnused;
                    issue(r, -1, '0);
                end
            end
        end
        steady = 1'b0;

        wait_drained();
        if (fail_count == 0 && awaited_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
